// ----- sv/sdsrs_pkg.sv -----
// Shared types and constants for the SD card SPI sector read sequencer.
package sdsrs_pkg;

  // Field widths
  localparam int SECTOR_W = 23;
  localparam int COUNT_W  = 10;
  localparam int POLL_W   = 16;
  localparam int WAKE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Request operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_SLOT  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_COUNT = 2'd1;

  // Register reset values
  localparam logic [POLL_W-1:0] RESET_TRY_LIMIT  = 16'd800;
  localparam logic [WAKE_W-1:0] RESET_WAKE_COUNT = 8'h0f;

  // Bus bytes
  localparam logic [7:0] CMD0_OP   = 8'h40;
  localparam logic [7:0] CMD0_CRC  = 8'h95;
  localparam logic [7:0] CMD1_OP   = 8'h41;
  localparam logic [7:0] CMD17_OP  = 8'h51;
  localparam logic [7:0] DATA_TOKEN = 8'hfe;
  localparam logic [7:0] FILL_BYTE = 8'hff;
  localparam logic [7:0] R1_IDLE   = 8'h01;
  localparam logic [7:0] R1_READY  = 8'h00;

  // Command frame: slots 1..6 carry bytes, slot 7 ends the frame
  localparam logic [COUNT_W-1:0] FRAME_END = 10'd7;
  localparam logic [COUNT_W-1:0] FRAME_LAST_BYTE = 10'd6;
  localparam logic [COUNT_W-1:0] CRC_BYTES = 10'd2;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_WAKE  = 4'd1,
    PH_RST_CMD   = 4'd2,
    PH_RST_POLL  = 4'd3,
    PH_GAP       = 4'd4,
    PH_INI_CMD   = 4'd5,
    PH_INI_POLL  = 4'd6,
    PH_INI_OK    = 4'd7,
    PH_INI_AGAIN = 4'd8,
    PH_RD_CMD    = 4'd9,
    PH_RD_POLL   = 4'd10,
    PH_TOKEN     = 4'd11,
    PH_DATA      = 4'd12,
    PH_CRC       = 4'd13,
    PH_TAIL      = 4'd14
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [COUNT_W-1:0]  byte_count;
    logic [POLL_W-1:0]   poll_count;
    logic [SECTOR_W-1:0] sector;
    logic                fast_mode;
  } seq_state_t;

  typedef struct packed {
    logic [POLL_W-1:0] try_limit;
    logic [WAKE_W-1:0] wake_count;
  } seq_cfg_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       select_active;
    logic       slow_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       busy_res;
    logic       done_res;
  } seq_result_t;

endpackage

// ----- sv/sdsrs_step.sv -----
// Next-state and result logic for one request of the sector read sequencer.
module sdsrs_step
  import sdsrs_pkg::*;
#(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                op,
  input  logic [SECTOR_W-1:0] sector_address,
  input  logic [7:0]          miso_byte,
  input  seq_state_t          st,
  input  seq_cfg_t            cfg,
  output seq_state_t          st_nxt,
  output seq_result_t         res
);

  localparam logic [COUNT_W:0] BLOCK_LEN = (COUNT_W+1)'(BLOCK_BYTES);

  logic [COUNT_W-1:0] bc_inc;
  logic [COUNT_W:0]   bc_inc_wide;
  logic [POLL_W-1:0]  poll_inc;
  logic [POLL_W-1:0]  lim_eff;
  logic [WAKE_W-1:0]  wake_eff;
  logic               miso_fill;
  logic               poll_end;
  logic               data_end;
  logic [2:0]         frame_idx;
  logic [7:0]         frame_byte;

  // Shared counters and compares
  assign bc_inc      = st.byte_count + 1'b1;
  assign bc_inc_wide = {1'b0, st.byte_count} + 1'b1;
  assign poll_inc    = st.poll_count + 1'b1;
  assign lim_eff     = (cfg.try_limit == '0) ? POLL_W'(1) : cfg.try_limit;
  assign wake_eff    = (cfg.wake_count == '0) ? WAKE_W'(1) : cfg.wake_count;
  assign miso_fill   = (miso_byte == FILL_BYTE);
  // a timed-out poll reads as 0xFF, which is the received byte anyway
  assign poll_end    = !miso_fill || (poll_inc >= lim_eff);
  assign data_end    = (bc_inc_wide >= BLOCK_LEN);

  // Next state
  always_comb begin
    st_nxt = st;
    if (op == OP_START) begin
      st_nxt.sector     = sector_address;
      st_nxt.fast_mode  = 1'b0;
      st_nxt.phase      = PH_RST_WAKE;
      st_nxt.byte_count = '0;
      st_nxt.poll_count = '0;
    end else begin
      case (st.phase)
        PH_RST_WAKE: begin
          if (bc_inc >= COUNT_W'(wake_eff)) begin
            st_nxt.phase      = PH_RST_CMD;
            st_nxt.byte_count = '0;
          end else begin
            st_nxt.byte_count = bc_inc;
          end
        end
        PH_RST_CMD, PH_INI_CMD, PH_RD_CMD: begin
          if (bc_inc >= FRAME_END) begin
            case (st.phase)
              PH_RST_CMD: st_nxt.phase = PH_RST_POLL;
              PH_INI_CMD: st_nxt.phase = PH_INI_POLL;
              default:    st_nxt.phase = PH_RD_POLL;
            endcase
            st_nxt.byte_count = '0;
            st_nxt.poll_count = '0;
          end else begin
            st_nxt.byte_count = bc_inc;
          end
        end
        PH_RST_POLL: begin
          if (miso_fill) st_nxt.poll_count = poll_inc;
          if (poll_end) begin
            st_nxt.phase      = (miso_byte == R1_IDLE) ? PH_GAP : PH_RST_WAKE;
            st_nxt.byte_count = '0;
          end
        end
        PH_GAP: begin
          st_nxt.phase      = PH_INI_CMD;
          st_nxt.byte_count = '0;
        end
        PH_INI_POLL: begin
          if (miso_fill) st_nxt.poll_count = poll_inc;
          if (poll_end) begin
            st_nxt.fast_mode = 1'b1;
            st_nxt.phase     = (miso_byte == R1_READY) ? PH_INI_OK : PH_INI_AGAIN;
          end
        end
        PH_INI_OK: begin
          st_nxt.phase      = PH_RD_CMD;
          st_nxt.byte_count = '0;
        end
        PH_INI_AGAIN: begin
          st_nxt.phase      = PH_INI_CMD;
          st_nxt.byte_count = '0;
        end
        PH_RD_POLL: begin
          if (miso_fill) st_nxt.poll_count = poll_inc;
          if (poll_end) begin
            st_nxt.phase      = (miso_byte == R1_READY) ? PH_TOKEN : PH_RD_CMD;
            st_nxt.byte_count = '0;
          end
        end
        PH_TOKEN: begin
          if (miso_byte == DATA_TOKEN) begin
            st_nxt.phase      = PH_DATA;
            st_nxt.byte_count = '0;
          end
        end
        PH_DATA: begin
          if (data_end) begin
            st_nxt.phase      = PH_CRC;
            st_nxt.byte_count = '0;
          end else begin
            st_nxt.byte_count = bc_inc;
          end
        end
        PH_CRC: begin
          if (bc_inc >= CRC_BYTES) begin
            st_nxt.phase      = PH_TAIL;
            st_nxt.byte_count = '0;
          end else begin
            st_nxt.byte_count = bc_inc;
          end
        end
        PH_TAIL: begin
          st_nxt.phase      = PH_IDLE;
          st_nxt.byte_count = '0;
        end
        default: begin
          st_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  // Pick the command byte for the upcoming slot
  assign frame_idx = st_nxt.byte_count[2:0] - 3'd1;

  always_comb begin
    frame_byte = FILL_BYTE;
    case (frame_idx)
      3'd0: begin
        case (st_nxt.phase)
          PH_RST_CMD: frame_byte = CMD0_OP;
          PH_INI_CMD: frame_byte = CMD1_OP;
          default:    frame_byte = CMD17_OP;
        endcase
      end
      3'd1: frame_byte = (st_nxt.phase == PH_RD_CMD) ? st_nxt.sector[22:15] : 8'h00;
      3'd2: frame_byte = (st_nxt.phase == PH_RD_CMD) ? st_nxt.sector[14:7] : 8'h00;
      3'd3: frame_byte = (st_nxt.phase == PH_RD_CMD) ? {st_nxt.sector[6:0], 1'b0} : 8'h00;
      3'd4: frame_byte = 8'h00;
      3'd5: frame_byte = (st_nxt.phase == PH_RST_CMD) ? CMD0_CRC : FILL_BYTE;
      default: frame_byte = FILL_BYTE;
    endcase
  end

  // Result for this request
  always_comb begin
    res               = '0;
    res.mosi_byte     = FILL_BYTE;
    res.slow_clock    = !st_nxt.fast_mode;
    res.busy_res      = (st_nxt.phase != PH_IDLE);
    case (st_nxt.phase)
      PH_RST_CMD, PH_INI_CMD, PH_RD_CMD: begin
        if (st_nxt.byte_count != '0 && st_nxt.byte_count <= FRAME_LAST_BYTE) begin
          res.mosi_byte     = frame_byte;
          res.select_active = 1'b1;
        end
      end
      PH_RST_POLL, PH_INI_POLL, PH_RD_POLL, PH_TOKEN, PH_DATA, PH_CRC: begin
        res.select_active = 1'b1;
      end
      default: begin
        res.select_active = 1'b0;
      end
    endcase
    if (op == OP_SLOT && st.phase == PH_DATA) begin
      res.data_valid = 1'b1;
      res.data_byte  = miso_byte;
      res.data_last  = data_end;
    end
    res.done_res = (op == OP_SLOT) && (st.phase == PH_TAIL);
  end

endmodule

// ----- sv/sd_spi_sector_read_sequencer.sv -----
// Top level of the SD card SPI-mode init and single-block read sequencer.
//
// Drive one start request (in_operation low, in_sector_address set), then
// one slot request per completed SPI byte exchange carrying the MISO byte.
// Every request yields exactly one result: the MOSI byte, select level and
// clock speed for the next slot, plus a sector data byte with a last flag
// while the block streams. busy_res drops and done_res rises on the result
// of the trailing 0xFF slot. A start while busy restarts from card reset.
// A request is taken into the input register, and the step logic feeds
// the result register from it. Throughput: one request per cycle while
// the result side does not stall; in use the rate is set by the SPI byte
// exchange. The result register frees the input side, so a request is
// still taken while one result waits. When the receiver stalls, the
// result holds, then the input register fills and in_ready drops.
// Reset (synchronous, rst_n low) sets the sequencer idle, clock slow, and
// the registers to a try limit of 800 polls and 15 wake bytes. Registers
// are written at any time through cfg_valid/cfg_ready; cfg_ready is high.
module sd_spi_sector_read_sequencer
  import sdsrs_pkg::*;
#(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [SECTOR_W-1:0]   in_sector_address,
  input  logic [7:0]            in_miso_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_mosi_byte,
  output logic                  out_select_active,
  output logic                  out_slow_clock,
  output logic                  out_data_valid,
  output logic [7:0]            out_data_byte,
  output logic                  out_data_last,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                in_valid_r;
  logic                op_r;
  logic [SECTOR_W-1:0] sector_r;
  logic [7:0]          miso_r;
  logic                out_valid_r;
  seq_result_t         res_r;
  seq_result_t         res_nxt;
  seq_state_t          st_r;
  seq_state_t          st_nxt;
  seq_cfg_t            cfg_r;
  logic                advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      sector_r <= in_sector_address;
      miso_r   <= in_miso_byte;
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.try_limit  <= RESET_TRY_LIMIT;
      cfg_r.wake_count <= RESET_WAKE_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRY_LIMIT:  cfg_r.try_limit  <= cfg_data;
        CFG_WAKE_COUNT: cfg_r.wake_count <= cfg_data[WAKE_W-1:0];
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  sdsrs_step #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_step (
    .op             (op_r),
    .sector_address (sector_r),
    .miso_byte      (miso_r),
    .st             (st_r),
    .cfg            (cfg_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  // Advance the sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mosi_byte     = res_r.mosi_byte;
  assign out_select_active = res_r.select_active;
  assign out_slow_clock    = res_r.slow_clock;
  assign out_data_valid    = res_r.data_valid;
  assign out_data_byte     = res_r.data_byte;
  assign out_data_last     = res_r.data_last;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;

  // Data bytes stream with the card selected
  a_data_selected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_select_active)
    else $error("data byte delivered while card deselected");

  // Completion leaves the card deselected and the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_select_active)
    else $error("done result while still busy or selected");

  // Last marker only on a data byte
  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_last |-> out_data_valid)
    else $error("last marker without data byte");

  // Idle slots send fill bytes
  a_idle_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_mosi_byte == FILL_BYTE)
    else $error("idle result carries a command byte");

  // A pending request is never dropped while the result side stalls
  a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(miso_r))
    else $error("stalled request lost");

endmodule

// ----- verif/sd_spi_sector_read_sequencer_test.sv -----
// Self-checking testbench for the SD card SPI sector read sequencer.
`timescale 1ns / 1ps

module sd_spi_sector_read_sequencer_test;
  import sdsrs_pkg::*;

  // Full-size sector blocks
  localparam int BLOCK_LEN = 512;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_LIMIT = 40;
  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_SLOT;
  logic [SECTOR_W-1:0]   in_sector_address = '0;
  logic [7:0]            in_miso_byte = FILL_BYTE;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_mosi_byte;
  logic                  out_select_active;
  logic                  out_slow_clock;
  logic                  out_data_valid;
  logic [7:0]            out_data_byte;
  logic                  out_data_last;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TRY_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted sequencer state and register copies
  phase_t              phase_q = PH_IDLE;
  logic [COUNT_W-1:0]  count_q = '0;
  logic [POLL_W-1:0]   polls_q = '0;
  logic [SECTOR_W-1:0] sector_q = '0;
  logic                fast_q = 1'b0;
  logic [POLL_W-1:0]   limit_q = RESET_TRY_LIMIT;
  logic [WAKE_W-1:0]   wake_q = RESET_WAKE_COUNT;

  seq_result_t pending_bus_steps[$];

  int  error_count = 0;
  int  request_count = 0;
  int  result_count = 0;
  int  data_count = 0;
  int  block_count = 0;
  int  setting_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1;

  sd_spi_sector_read_sequencer #(
    .BLOCK_BYTES(BLOCK_LEN)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sector_address (in_sector_address),
    .in_miso_byte      (in_miso_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mosi_byte     (out_mosi_byte),
    .out_select_active (out_select_active),
    .out_slow_clock    (out_slow_clock),
    .out_data_valid    (out_data_valid),
    .out_data_byte     (out_data_byte),
    .out_data_last     (out_data_last),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // End the run if the sequencer stops answering
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    out_ready <= (stall_left == 0);
  end

  // Advance the predicted state by one request and return the bus step it yields
  function automatic seq_result_t step_sequencer(input logic op,
                                                 input logic [SECTOR_W-1:0] sec,
                                                 input logic [7:0] miso);
    seq_result_t       r;
    logic [POLL_W-1:0] lim;
    logic [WAKE_W-1:0] wake;
    logic              ended;
    logic [7:0]        resp;
    r = '0;
    lim = (limit_q == '0) ? POLL_W'(1) : limit_q;
    wake = (wake_q == '0) ? WAKE_W'(1) : wake_q;
    ended = 1'b0;
    resp = FILL_BYTE;
    if (op == OP_START) begin
      sector_q = sec;
      fast_q = 1'b0;
      phase_q = PH_RST_WAKE;
      count_q = '0;
      polls_q = '0;
    end else begin
      // Response poll: ends on a non-fill byte or after the try limit
      if (phase_q == PH_RST_POLL || phase_q == PH_INI_POLL || phase_q == PH_RD_POLL) begin
        if (miso != FILL_BYTE) begin
          ended = 1'b1;
          resp = miso;
        end else begin
          polls_q = polls_q + 1'b1;
          if (polls_q >= lim) ended = 1'b1;
        end
      end
      case (phase_q)
        PH_RST_WAKE: begin
          count_q = count_q + 1'b1;
          if (count_q >= wake) begin
            phase_q = PH_RST_CMD;
            count_q = '0;
          end
        end
        PH_RST_CMD, PH_INI_CMD, PH_RD_CMD: begin
          count_q = count_q + 1'b1;
          if (count_q >= FRAME_END) begin
            phase_q = phase_t'(phase_q + 4'd1);
            count_q = '0;
            polls_q = '0;
          end
        end
        PH_RST_POLL: begin
          if (ended) begin
            phase_q = (resp == R1_IDLE) ? PH_GAP : PH_RST_WAKE;
            count_q = '0;
          end
        end
        PH_GAP: begin
          phase_q = PH_INI_CMD;
          count_q = '0;
        end
        PH_INI_POLL: begin
          if (ended) begin
            fast_q = 1'b1;
            phase_q = (resp == R1_READY) ? PH_INI_OK : PH_INI_AGAIN;
          end
        end
        PH_INI_OK: begin
          phase_q = PH_RD_CMD;
          count_q = '0;
        end
        PH_INI_AGAIN: begin
          phase_q = PH_INI_CMD;
          count_q = '0;
        end
        PH_RD_POLL: begin
          if (ended) begin
            phase_q = (resp == R1_READY) ? PH_TOKEN : PH_RD_CMD;
            count_q = '0;
          end
        end
        PH_TOKEN: begin
          if (miso == DATA_TOKEN) begin
            phase_q = PH_DATA;
            count_q = '0;
          end
        end
        PH_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte = miso;
          if (int'(count_q) + 1 >= BLOCK_LEN) begin
            r.data_last = 1'b1;
            phase_q = PH_CRC;
            count_q = '0;
          end else begin
            count_q = count_q + 1'b1;
          end
        end
        PH_CRC: begin
          count_q = count_q + 1'b1;
          if (count_q >= CRC_BYTES) begin
            phase_q = PH_TAIL;
            count_q = '0;
          end
        end
        PH_TAIL: begin
          phase_q = PH_IDLE;
          count_q = '0;
          r.done_res = 1'b1;
        end
        default: phase_q = PH_IDLE;
      endcase
    end
    // Bus settings for the next slot
    r.mosi_byte = FILL_BYTE;
    r.select_active = 1'b0;
    case (phase_q)
      PH_RST_CMD, PH_INI_CMD, PH_RD_CMD: begin
        if (count_q != '0 && count_q <= FRAME_LAST_BYTE) begin
          r.select_active = 1'b1;
          case (count_q)
            10'd1: r.mosi_byte = (phase_q == PH_RST_CMD) ? CMD0_OP :
                                 (phase_q == PH_INI_CMD) ? CMD1_OP : CMD17_OP;
            10'd2: r.mosi_byte = (phase_q == PH_RD_CMD) ? sector_q[22:15] : 8'h00;
            10'd3: r.mosi_byte = (phase_q == PH_RD_CMD) ? sector_q[14:7] : 8'h00;
            10'd4: r.mosi_byte = (phase_q == PH_RD_CMD) ? {sector_q[6:0], 1'b0} : 8'h00;
            10'd5: r.mosi_byte = 8'h00;
            default: r.mosi_byte = (phase_q == PH_RST_CMD) ? CMD0_CRC : FILL_BYTE;
          endcase
        end
      end
      PH_RST_POLL, PH_INI_POLL, PH_RD_POLL, PH_TOKEN, PH_DATA, PH_CRC: begin
        r.select_active = 1'b1;
      end
      default: ;
    endcase
    r.slow_clock = ~fast_q;
    r.busy_res = (phase_q != PH_IDLE);
    return r;
  endfunction

  // Pick a plausible card answer for the slot the sequencer is in
  function automatic logic [7:0] card_reply();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 8'($urandom);
    case (phase_q)
      PH_RST_POLL, PH_INI_POLL, PH_RD_POLL: begin
        if (pick < 45) return FILL_BYTE;
        if (pick < 55) return 8'($urandom_range(2, 254));
        if (phase_q == PH_RST_POLL) return R1_IDLE;
        // card still initializing
        if (phase_q == PH_INI_POLL && pick < 70) return R1_IDLE;
        return R1_READY;
      end
      PH_TOKEN: return (pick < 60) ? FILL_BYTE : DATA_TOKEN;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("Mismatch at result %0d, %s: got %0h expected %0h",
               result_count, field, got, want);
    end
  endtask

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    seq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_bus_steps.size() == 0) begin
        report_mismatch("result with no request", 1, 0);
      end else begin
        want = pending_bus_steps.pop_front();
        if (want.data_valid) data_count++;
        if (want.done_res) block_count++;
        if (out_mosi_byte !== want.mosi_byte)
          report_mismatch("mosi_byte", out_mosi_byte, want.mosi_byte);
        if (out_select_active !== want.select_active)
          report_mismatch("select_active", out_select_active, want.select_active);
        if (out_slow_clock !== want.slow_clock)
          report_mismatch("slow_clock", out_slow_clock, want.slow_clock);
        if (out_data_valid !== want.data_valid)
          report_mismatch("data_valid", out_data_valid, want.data_valid);
        if (out_data_byte !== want.data_byte)
          report_mismatch("data_byte", out_data_byte, want.data_byte);
        if (out_data_last !== want.data_last)
          report_mismatch("data_last", out_data_last, want.data_last);
        if (out_busy_res !== want.busy_res)
          report_mismatch("busy_res", out_busy_res, want.busy_res);
        if (out_done_res !== want.done_res)
          report_mismatch("done_res", out_done_res, want.done_res);
      end
    end
  end

  // Send one request; called at a falling edge, returns at a falling edge
  task automatic send_request(input logic op, input logic [SECTOR_W-1:0] sec,
                              input logic [7:0] miso);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_sector_address <= sec;
    in_miso_byte <= miso;
    do @(posedge clk); while (!in_ready);
    pending_bus_steps.push_back(step_sequencer(op, sec, miso));
    request_count++;
    @(negedge clk);
  endtask

  // Hold off until every predicted result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_bus_steps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TRY_LIMIT) limit_q = value;
    else if (idx == CFG_WAKE_COUNT) wake_q = value[WAKE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed card traffic, with restarts and stray slots mixed in
  task automatic random_traffic(input int count);
    int                  sent;
    int                  pick;
    logic [SECTOR_W-1:0] sec;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 199);
      sec = SECTOR_W'($urandom);
      if (pick < 10) sec = '0;
      else if (pick < 20) sec = '1;
      if (phase_q == PH_IDLE) begin
        if (pick % 8 == 0) begin
          send_request(OP_SLOT, SECTOR_W'($urandom), 8'($urandom));
        end else begin
          send_request(OP_START, sec, 8'($urandom));
          sent++;
        end
      end else if (pick == 0 && phase_q != PH_DATA) begin
        // leave a streaming block alone so that whole reads complete
        send_request(OP_START, sec, 8'($urandom));
        sent++;
      end else begin
        send_request(OP_SLOT, SECTOR_W'($urandom), card_reply());
        sent++;
      end
    end
  endtask

  task automatic run_setting(input logic [CFG_DATA_W-1:0] limit,
                             input logic [CFG_DATA_W-1:0] wake, input int count);
    drain_results();
    write_reg(CFG_TRY_LIMIT, limit);
    write_reg(CFG_WAKE_COUNT, wake);
    setting_count++;
    random_traffic(count);
  endtask

  // Slots with no sequence running leave the bus idle
  task automatic test_idle_slots();
    send_request(OP_SLOT, '1, 8'h00);
    send_request(OP_SLOT, '0, FILL_BYTE);
  endtask

  // A start in the middle of a sequence goes back to card reset
  task automatic test_restart_while_busy();
    send_request(OP_START, '1, 8'h00);
    repeat (3) send_request(OP_SLOT, '0, FILL_BYTE);
    send_request(OP_START, '0, FILL_BYTE);
    repeat (2) send_request(OP_SLOT, '1, 8'h5a);
  endtask

  // Zero wake count and zero try limit each behave as one
  task automatic test_zero_counts();
    drain_results();
    write_reg(CFG_WAKE_COUNT, '0);
    write_reg(CFG_TRY_LIMIT, '0);
    setting_count++;
    send_request(OP_START, SECTOR_W'($urandom), 8'h00);
    send_request(OP_SLOT, '0, FILL_BYTE);
    repeat (7) send_request(OP_SLOT, '0, 8'($urandom));
    send_request(OP_SLOT, '0, FILL_BYTE);
    send_request(OP_SLOT, '0, R1_IDLE);
  endtask

  // Writes to unused indexes change nothing
  task automatic test_spare_registers();
    drain_results();
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, '1);
    random_traffic(40);
  endtask

  task automatic test_random_settings();
    run_setting(16'd3, 16'd2, 240);
    run_setting(16'd1, 16'd1, 200);
    // extremes; upper data bits of the wake write are dropped
    run_setting(16'hffff, 16'hffff, 200);
    run_setting(RESET_TRY_LIMIT, RESET_WAKE_COUNT, 220);
    run_setting(16'd0, 16'd0, 200);
    // pause the sender mid-setting until everything is back
    run_setting(16'd2, 16'd5, 100);
    drain_results();
    random_traffic(100);
  endtask

  // Finish with no idling on either side
  task automatic test_quiet_tail();
    gaps_on = 1'b0;
    run_setting(16'd4, 16'd3, 300);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_slots();
    test_restart_while_busy();
    test_zero_counts();
    test_spare_registers();
    test_random_settings();
    test_quiet_tail();

    drain_results();
    repeat (10) @(negedge clk);
    $display("Covered %0d requests and %0d results over %0d register settings.",
             request_count, result_count, setting_count);
    $display("Completed %0d block reads, streaming %0d sector data bytes.",
             block_count, data_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sdsrs_pkg.sv
sv/sdsrs_step.sv
sv/sd_spi_sector_read_sequencer.sv
verif/sd_spi_sector_read_sequencer_test.sv
